/* rtl/core/rars_pkg.sv */
// ----------------------------------------------------------------------------
// rars_pkg
// Shared types and constants of the range-add / range-sum core.
// ----------------------------------------------------------------------------
package rars_pkg;

    localparam int KIND_W           = 2;
    localparam int IDX_W            = 10;
    localparam int VAL_W            = 64;
    localparam int CFG_W            = 11;
    localparam int DEF_MAX_ELEMENTS = 1024;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_START,
        ST_U_MUL,
        ST_U_SET,
        ST_U_RD,
        ST_U_WR,
        ST_Q_BASE,
        ST_Q_BASE_W,
        ST_Q_WALK_RD,
        ST_Q_WALK_ACC,
        ST_Q_MUL,
        ST_Q_FIN,
        ST_DONE
    } rars_state_t;

endpackage

/* rtl/core/rars_ram.sv */
// ----------------------------------------------------------------------------
// rars_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rars_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/rars_mul.sv */
// ----------------------------------------------------------------------------
// rars_mul
// Shared multiplier: 64-bit value times an unsigned tree position, result
// registered and kept modulo 2^64.
// ----------------------------------------------------------------------------
module rars_mul #(
    parameter int IW = 11
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [rars_pkg::VAL_W-1:0] a,
    input  logic [IW-1:0]             b,
    output logic [rars_pkg::VAL_W-1:0] prod
);
    import rars_pkg::*;

    logic [VAL_W-1:0] prod_reg;
    logic [VAL_W-1:0] prod_next;

    assign prod_next = a * VAL_W'(b);

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/range_add_range_sum_tree_core.sv */
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_core
// Signed 64-bit array with range add and range sum, wrapping modulo 2^64.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: tuser carries the kind (load, add, sum),
// tdata the first index, last index and value. Each request gives exactly one
// result on the m_ channel: tdata is the range sum (zero unless a valid sum),
// tuser flags a refused request. cfg_we/cfg_wdata set the element count.
// The array is kept as a prefix table of the loaded values plus two indexed
// add trees; one shared multiplier and one sequencer walk them.
// A load writes its value straight into the prefix RAM. An add or sum walks
// the add trees one level per read-modify-write or accumulate step, each
// step waiting on the registered RAM read before it goes on.
// The first add or sum also builds the prefix table from the loaded values.
// After reset a clearing pass zeroes the RAMs; s_tready stays low meanwhile.
// One request is in flight at a time; s_tready is high only while the
// sequencer is idle. A finished result waits in the output register while
// the next request is accepted; when the receiver stalls with a result still
// held, the next result waits inside the core until the register frees.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_core #(
    parameter int MAX_ELEMENTS = rars_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config: elements in use
    input  logic                          cfg_we,
    input  logic [rars_pkg::CFG_W-1:0]    cfg_wdata,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: first_index[9:0], last_index[19:10], value[83:20], zero pad
    input  logic [87:0]                   s_tdata,
    // tuser: kind[1:0]
    input  logic [rars_pkg::KIND_W-1:0]   s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: range_sum[63:0]
    output logic [rars_pkg::VAL_W-1:0]    m_tdata,
    // tuser: range_error[0]
    output logic                          m_tuser
);
    import rars_pkg::*;

    localparam int LEAVES = 1 << $clog2(MAX_ELEMENTS);
    localparam int AW     = $clog2(LEAVES);
    localparam int FW     = AW + 1;
    localparam int JW     = FW + 1;
    localparam int CW     = (FW > CFG_W) ? FW : CFG_W;

    rars_state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_reg;
    logic              loading_open_reg, loading_open_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]  f_reg, f_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [VAL_W-1:0]  v_reg, v_next;
    logic              phase_reg, phase_next;
    logic [JW-1:0]     j_reg, j_next;
    logic [FW-1:0]     p_reg, p_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic [VAL_W-1:0]  acc1_reg, acc1_next;
    logic [VAL_W-1:0]  acc2_reg, acc2_next;
    logic [VAL_W-1:0]  total_reg, total_next;
    logic [VAL_W-1:0]  d1_reg, d1_next;
    logic [VAL_W-1:0]  d2_reg, d2_next;
    logic              err_reg, err_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]  m_sum_reg, m_sum_next;
    logic              m_err_reg, m_err_next;

    // ram ports
    logic              q_we;
    logic [AW-1:0]     q_waddr, q_raddr;
    logic [VAL_W-1:0]  q_wdata, q_rdata;
    logic              b_we;
    logic [FW-1:0]     b_addr;
    logic [VAL_W-1:0]  b1_wdata, b2_wdata, b1_rdata, b2_rdata;

    // shared multiplier
    logic              mul_en;
    logic [VAL_W-1:0]  mul_a, prod;
    logic [FW-1:0]     mul_b;

    // range checks
    logic [CW-1:0]     n_raw, n_eff, f_c, r_c;
    logic              load_bad, range_bad;
    logic [JW-1:0]     j_low;
    logic [FW-1:0]     pm1;
    logic [VAL_W-1:0]  bsum, pref;

    assign n_raw = CW'(cfg_reg);
    assign n_eff = (n_raw == '0) ? CW'(1) :
                   ((n_raw > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : n_raw);
    assign f_c       = CW'(f_reg);
    assign r_c       = CW'(r_reg);
    assign load_bad  = !loading_open_reg || (f_c >= n_eff);
    assign range_bad = (f_c > r_c) || (r_c >= n_eff);
    // lowest set bit of the walk index
    assign j_low     = j_reg & (~j_reg + JW'(1));
    assign pm1       = p_reg - FW'(1);
    assign bsum      = acc_reg + q_rdata;
    assign pref      = acc_reg + prod - acc2_reg;

    rars_ram #(.WIDTH(VAL_W), .DEPTH(LEAVES)) u_prefix_ram (
        .clk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    rars_ram #(.WIDTH(VAL_W), .DEPTH(LEAVES + 1)) u_add_ram (
        .clk(aclk), .we(b_we), .waddr(b_addr), .wdata(b1_wdata),
        .raddr(b_addr), .rdata(b1_rdata)
    );

    rars_ram #(.WIDTH(VAL_W), .DEPTH(LEAVES + 1)) u_wadd_ram (
        .clk(aclk), .we(b_we), .waddr(b_addr), .wdata(b2_wdata),
        .raddr(b_addr), .rdata(b2_rdata)
    );

    rars_mul #(.IW(FW)) u_mul (
        .clk(aclk), .en(mul_en), .a(mul_a), .b(mul_b), .prod(prod)
    );

    assign mul_en = (state_reg == ST_U_MUL) || (state_reg == ST_Q_MUL);
    assign mul_a  = (state_reg == ST_Q_MUL) ? acc1_reg : v_reg;
    // the end correction uses one past the last index
    assign mul_b  = (state_reg == ST_Q_MUL) ? p_reg :
                    (phase_reg ? (FW'(r_reg) + FW'(1)) : FW'(f_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            cfg_reg          <= CFG_RESET;
            loading_open_reg <= 1'b1;
            m_tvalid_reg     <= 1'b0;
            j_reg            <= '0;
        end else begin
            state_reg        <= state_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            loading_open_reg <= loading_open_next;
            m_tvalid_reg     <= m_tvalid_next;
            j_reg            <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        f_reg     <= f_next;
        r_reg     <= r_next;
        v_reg     <= v_next;
        phase_reg <= phase_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        acc1_reg  <= acc1_next;
        acc2_reg  <= acc2_next;
        total_reg <= total_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        err_reg   <= err_next;
        m_sum_reg <= m_sum_next;
        m_err_reg <= m_err_next;
    end

    always_comb begin
        state_next        = state_reg;
        loading_open_next = loading_open_reg;
        kind_next         = kind_reg;
        f_next            = f_reg;
        r_next            = r_reg;
        v_next            = v_reg;
        phase_next        = phase_reg;
        j_next            = j_reg;
        p_next            = p_reg;
        acc_next          = acc_reg;
        acc1_next         = acc1_reg;
        acc2_next         = acc2_reg;
        total_next        = total_reg;
        d1_next           = d1_reg;
        d2_next           = d2_reg;
        err_next          = err_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_sum_next        = m_sum_reg;
        m_err_next        = m_err_reg;
        s_tready          = 1'b0;
        q_we              = 1'b0;
        q_waddr           = j_reg[AW-1:0];
        q_wdata           = '0;
        q_raddr           = j_reg[AW-1:0];
        b_we              = 1'b0;
        b_addr            = j_reg[FW-1:0];
        b1_wdata          = '0;
        b2_wdata          = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                q_we = (j_reg < JW'(LEAVES));
                b_we = 1'b1;
                j_next = j_reg + JW'(1);
                if (j_reg == JW'(LEAVES)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    f_next     = s_tdata[9:0];
                    r_next     = s_tdata[19:10];
                    v_next     = s_tdata[83:20];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                err_next   = 1'b0;
                total_next = '0;
                unique case (kind_reg)
                    KIND_LOAD: begin
                        err_next   = load_bad;
                        q_we       = !load_bad;
                        q_waddr    = AW'(f_reg);
                        q_wdata    = v_reg;
                        state_next = ST_DONE;
                    end
                    KIND_ADD, KIND_SUM: begin
                        j_next   = '0;
                        acc_next = '0;
                        state_next = loading_open_reg ? ST_BUILD_RD : ST_START;
                    end
                    default: begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_BUILD_RD: begin
                state_next = ST_BUILD_WR;
            end
            ST_BUILD_WR: begin
                // running prefix written back in place
                q_we     = 1'b1;
                q_wdata  = bsum;
                acc_next = bsum;
                j_next   = j_reg + JW'(1);
                if (j_reg == JW'(LEAVES - 1)) begin
                    loading_open_next = 1'b0;
                    state_next        = ST_START;
                end else begin
                    state_next = ST_BUILD_RD;
                end
            end
            ST_START: begin
                phase_next = 1'b0;
                if (range_bad) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (kind_reg == KIND_ADD) begin
                    state_next = ST_U_MUL;
                end else begin
                    p_next     = FW'(r_reg) + FW'(1);
                    state_next = ST_Q_BASE;
                end
            end
            ST_U_MUL: begin
                state_next = ST_U_SET;
            end
            ST_U_SET: begin
                d1_next    = phase_reg ? (VAL_W'(0) - v_reg) : v_reg;
                d2_next    = phase_reg ? (VAL_W'(0) - prod) : prod;
                j_next     = phase_reg ? (JW'(r_reg) + JW'(1)) : (JW'(f_reg) + JW'(1));
                state_next = ST_U_RD;
            end
            ST_U_RD: begin
                if (j_reg > JW'(LEAVES)) begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                        state_next = ST_U_MUL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_U_WR;
                end
            end
            ST_U_WR: begin
                b_we       = 1'b1;
                b1_wdata   = b1_rdata + d1_reg;
                b2_wdata   = b2_rdata + d2_reg;
                j_next     = j_reg + j_low;
                state_next = ST_U_RD;
            end
            ST_Q_BASE: begin
                q_raddr    = pm1[AW-1:0];
                state_next = ST_Q_BASE_W;
            end
            ST_Q_BASE_W: begin
                acc_next   = (p_reg != '0) ? q_rdata : '0;
                acc1_next  = '0;
                acc2_next  = '0;
                j_next     = JW'(p_reg);
                state_next = ST_Q_WALK_RD;
            end
            ST_Q_WALK_RD: begin
                state_next = (j_reg == '0) ? ST_Q_MUL : ST_Q_WALK_ACC;
            end
            ST_Q_WALK_ACC: begin
                acc1_next  = acc1_reg + b1_rdata;
                acc2_next  = acc2_reg + b2_rdata;
                j_next     = j_reg - j_low;
                state_next = ST_Q_WALK_RD;
            end
            ST_Q_MUL: begin
                state_next = ST_Q_FIN;
            end
            ST_Q_FIN: begin
                total_next = phase_reg ? (total_reg - pref) : pref;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    p_next     = FW'(f_reg);
                    state_next = ST_Q_BASE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sum_next    = total_reg;
                    m_err_next    = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_sum_reg;
    assign m_tuser  = m_err_reg;

    // loading never reopens once closed
    a_load_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        !loading_open_reg |=> !loading_open_reg)
        else $error("loading reopened");

    // a refused request carries a zero sum
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("refused request with nonzero sum");

    // the query walk stays inside the add trees
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_Q_WALK_ACC |-> j_reg <= JW'(LEAVES))
        else $error("query walk out of range");

endmodule
